/* hdl/glyph_row_pixel_writer_macros.svh */
// Assertion macros for the glyph row pixel writer.
// No dependencies; included by the files that carry assertions.
`ifndef GLYPH_ROW_PIXEL_WRITER_MACROS_SVH
`define GLYPH_ROW_PIXEL_WRITER_MACROS_SVH
`ifndef SYNTH
`define GRPW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("grpw assertion failed");
`define GRPW_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("grpw forbidden condition seen");
`else
`define GRPW_ASSERT(lbl, clk, rst_n, prop)
`define GRPW_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hdl/grpw_pkg.sv */
// Shared widths, register indexes, controller states and the command and
// status structs of the glyph row pixel writer. No dependencies.
package grpw_pkg;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned ColorW = 64;
  localparam int unsigned BitsW  = 8;
  localparam int unsigned WidthW = 4;
  localparam int unsigned CoordW = 16;
  localparam int unsigned PitchW = 16;
  localparam int unsigned BppW   = 4;
  localparam int unsigned ColW   = 3;
  localparam int unsigned YsumW  = CoordW + 1;
  localparam int unsigned Prod1W = YsumW + PitchW;
  localparam int unsigned Prod2W = Prod1W + BppW;
  localparam int unsigned XoffW  = CoordW + BppW;
  localparam int unsigned PaddrW = 5;
  localparam int unsigned PdataW = 64;
  localparam int unsigned RegIdxW = 2;
  localparam int unsigned LeftBit = BitsW - 1;

  localparam logic [RegIdxW-1:0] RegBase  = 2'd0;
  localparam logic [RegIdxW-1:0] RegPitch = 2'd1;
  localparam logic [RegIdxW-1:0] RegBpp   = 2'd2;

  localparam logic [BppW-1:0] BppReset = 4'd4;

  typedef enum logic [2:0] {
    StIdle,
    StMulLine,
    StMulBpp,
    StSum,
    StEmit
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_line;
    logic mul_bpp;
    logic sum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic zero_width;
    logic last_col;
  } status_t;

endpackage

/* hdl/grpw_stream_if.sv */
// Valid/ready channel interfaces for glyph rows in and pixel writes out.
// Depends on grpw_pkg for field widths.
interface grpw_in_if;
  logic                          valid;
  logic                          ready;
  logic [grpw_pkg::BitsW-1:0]    row_bits;
  logic [grpw_pkg::WidthW-1:0]   glyph_width;
  logic [grpw_pkg::CoordW-1:0]   origin_x;
  logic [grpw_pkg::CoordW-1:0]   origin_y;
  logic [grpw_pkg::ColorW-1:0]   fore_color;
  logic [grpw_pkg::ColorW-1:0]   back_color;
  logic                          last_row;

  modport source (output valid, row_bits, glyph_width, origin_x, origin_y,
                  fore_color, back_color, last_row, input ready);
  modport sink (input valid, row_bits, glyph_width, origin_x, origin_y,
                fore_color, back_color, last_row, output ready);
endinterface

interface grpw_out_if;
  logic                          valid;
  logic                          ready;
  logic [grpw_pkg::AddrW-1:0]    pixel_address;
  logic [grpw_pkg::ColorW-1:0]   pixel_color;
  logic                          row_done;

  modport source (output valid, pixel_address, pixel_color, row_done, input ready);
  modport sink (input valid, pixel_address, pixel_color, row_done, output ready);
endinterface

/* hdl/glyph_row_pixel_writer.sv */
// Glyph row pixel writer: expands one glyph bitmap row into pixel writes.
// An item is accepted, then passes two multiplier stages and one address
// add, then gives one write beat per column of the clamped width as the
// output register frees; a zero-width row is only accepted.
// Reset (async, low) clears the row counter, the controller and the
// registers (pixel size to 4).
`include "glyph_row_pixel_writer_macros.svh"

module glyph_row_pixel_writer #(
  parameter int unsigned MAX_GLYPH_ROWS  = 32,
  parameter int unsigned MAX_GLYPH_WIDTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  grpw_in_if.sink                       in_i,
  grpw_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [grpw_pkg::PaddrW-1:0]   paddr,
  input  logic [grpw_pkg::PdataW-1:0]   pwdata,
  output logic [grpw_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  grpw_pkg::cmd_t              cmd;
  grpw_pkg::status_t           status;
  logic [grpw_pkg::AddrW-1:0]  base;
  logic [grpw_pkg::PitchW-1:0] pitch;
  logic [grpw_pkg::BppW-1:0]   bpp;

  grpw_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .base_o  (base),
    .pitch_o (pitch),
    .bpp_o   (bpp)
  );

  grpw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  grpw_datapath #(
    .MAX_GLYPH_ROWS  (MAX_GLYPH_ROWS),
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .row_bits_i      (in_i.row_bits),
    .glyph_width_i   (in_i.glyph_width),
    .origin_x_i      (in_i.origin_x),
    .origin_y_i      (in_i.origin_y),
    .fore_color_i    (in_i.fore_color),
    .back_color_i    (in_i.back_color),
    .last_row_i      (in_i.last_row),
    .base_i          (base),
    .pitch_i         (pitch),
    .bpp_i           (bpp),
    .pixel_address_o (out_o.pixel_address),
    .pixel_color_o   (out_o.pixel_color),
    .row_done_o      (out_o.row_done)
  );

  // a nonzero row keeps the input closed while it expands
  `GRPW_ASSERT(a_busy_after_row, clk_i, rst_ni, in_i.valid && in_i.ready && !status.zero_width |=> !in_i.ready)
  // hold a stalled beat until it is taken
  `GRPW_ASSERT(a_hold_beat, clk_i, rst_ni, out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.pixel_address))
  `GRPW_ASSERT(a_one_cmd, clk_i, rst_ni, $onehot0({cmd.load, cmd.mul_line, cmd.mul_bpp, cmd.sum, cmd.emit}))
  `GRPW_ASSERT_NEVER(a_no_emit_idle, clk_i, rst_ni, in_i.ready && cmd.emit)

endmodule

/* hdl/grpw_cfg_regs.sv */
// APB-style configuration registers: buffer base, scanline pitch, pixel size.
// Depends on grpw_pkg.
module grpw_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [grpw_pkg::PaddrW-1:0]   paddr,
  input  logic [grpw_pkg::PdataW-1:0]   pwdata,
  output logic [grpw_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output logic [grpw_pkg::AddrW-1:0]    base_o,
  output logic [grpw_pkg::PitchW-1:0]   pitch_o,
  output logic [grpw_pkg::BppW-1:0]     bpp_o
);

  logic [grpw_pkg::AddrW-1:0]   base_q;
  logic [grpw_pkg::PitchW-1:0]  pitch_q;
  logic [grpw_pkg::BppW-1:0]    bpp_q;
  logic [grpw_pkg::RegIdxW-1:0] idx;
  logic                         wr_en;

  // registers sit on 8-byte strides
  assign idx   = paddr[grpw_pkg::PaddrW-1:3];
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      pitch_q <= '0;
      bpp_q   <= grpw_pkg::BppReset;
    end else if (wr_en) begin
      unique case (idx)
        grpw_pkg::RegBase:  base_q  <= pwdata[grpw_pkg::AddrW-1:0];
        grpw_pkg::RegPitch: pitch_q <= pwdata[grpw_pkg::PitchW-1:0];
        grpw_pkg::RegBpp:   bpp_q   <= pwdata[grpw_pkg::BppW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      grpw_pkg::RegBase:  prdata = base_q;
      grpw_pkg::RegPitch: prdata = grpw_pkg::PdataW'(pitch_q);
      grpw_pkg::RegBpp:   prdata = grpw_pkg::PdataW'(bpp_q);
      default:            prdata = '0;
    endcase
  end

  assign base_o  = base_q;
  assign pitch_o = pitch_q;
  assign bpp_o   = bpp_q;

endmodule

/* hdl/grpw_ctrl.sv */
// Controller: sequences address arithmetic and per-column emission, owns the
// handshakes and the output valid flag. Depends on grpw_pkg.
module grpw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  grpw_pkg::status_t  status_i,
  output grpw_pkg::cmd_t     cmd_o
);

  grpw_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= grpw_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      grpw_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // a zero-width row only moves the row counter
          if (!status_i.zero_width) state_d = grpw_pkg::StMulLine;
        end
      end
      grpw_pkg::StMulLine: begin
        cmd_o.mul_line = 1'b1;
        state_d        = grpw_pkg::StMulBpp;
      end
      grpw_pkg::StMulBpp: begin
        cmd_o.mul_bpp = 1'b1;
        state_d       = grpw_pkg::StSum;
      end
      grpw_pkg::StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = grpw_pkg::StEmit;
      end
      grpw_pkg::StEmit: begin
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (status_i.last_col) state_d = grpw_pkg::StIdle;
        end
      end
      default: state_d = grpw_pkg::StIdle;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/grpw_datapath.sv */
// Datapath: row counter, line and column address arithmetic, column walk
// and the output beat register. Depends on grpw_pkg.
module grpw_datapath #(
  parameter int unsigned MAX_GLYPH_ROWS  = 32,
  parameter int unsigned MAX_GLYPH_WIDTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  grpw_pkg::cmd_t                cmd_i,
  output grpw_pkg::status_t             status_o,
  input  logic [grpw_pkg::BitsW-1:0]    row_bits_i,
  input  logic [grpw_pkg::WidthW-1:0]   glyph_width_i,
  input  logic [grpw_pkg::CoordW-1:0]   origin_x_i,
  input  logic [grpw_pkg::CoordW-1:0]   origin_y_i,
  input  logic [grpw_pkg::ColorW-1:0]   fore_color_i,
  input  logic [grpw_pkg::ColorW-1:0]   back_color_i,
  input  logic                          last_row_i,
  input  logic [grpw_pkg::AddrW-1:0]    base_i,
  input  logic [grpw_pkg::PitchW-1:0]   pitch_i,
  input  logic [grpw_pkg::BppW-1:0]     bpp_i,
  output logic [grpw_pkg::AddrW-1:0]    pixel_address_o,
  output logic [grpw_pkg::ColorW-1:0]   pixel_color_o,
  output logic                          row_done_o
);

  localparam int unsigned RowW = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;
  localparam logic [RowW-1:0] RowTop = RowW'(MAX_GLYPH_ROWS - 1);
  localparam logic [grpw_pkg::WidthW-1:0] WidthMax = grpw_pkg::WidthW'(MAX_GLYPH_WIDTH);

  logic [RowW-1:0]               row_q;
  logic [grpw_pkg::YsumW-1:0]    ysum_q;
  logic [grpw_pkg::CoordW-1:0]   ox_q;
  logic [grpw_pkg::BitsW-1:0]    bits_q;
  logic [grpw_pkg::ColorW-1:0]   fg_q, bg_q;
  logic [grpw_pkg::WidthW-1:0]   w_q;
  logic [grpw_pkg::ColW-1:0]     col_q;
  logic [grpw_pkg::Prod1W-1:0]   prod1_q;
  logic [grpw_pkg::XoffW-1:0]    xoff_q;
  logic [grpw_pkg::Prod2W-1:0]   prod2_q;
  logic [grpw_pkg::AddrW-1:0]    addr_q;
  logic [grpw_pkg::AddrW-1:0]    out_addr_q;
  logic [grpw_pkg::ColorW-1:0]   out_color_q;
  logic                          out_done_q;
  logic [grpw_pkg::WidthW-1:0]   w_clamped;
  logic [grpw_pkg::WidthW-1:0]   col_next;

  assign w_clamped = (glyph_width_i > WidthMax) ? WidthMax : glyph_width_i;
  assign col_next  = grpw_pkg::WidthW'(col_q) + grpw_pkg::WidthW'(1);

  assign status_o.zero_width = (w_clamped == '0);
  assign status_o.last_col   = (col_next == w_q);

  // row counter: clear after the last row, saturate at the top row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (cmd_i.load) begin
      if (last_row_i)          row_q <= '0;
      else if (row_q < RowTop) row_q <= row_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ysum_q <= grpw_pkg::YsumW'(origin_y_i) + grpw_pkg::YsumW'(row_q);
      ox_q   <= origin_x_i;
      bits_q <= row_bits_i;
      fg_q   <= fore_color_i;
      bg_q   <= back_color_i;
      w_q    <= w_clamped;
      col_q  <= '0;
    end
    if (cmd_i.mul_line) begin
      prod1_q <= grpw_pkg::Prod1W'(ysum_q) * grpw_pkg::Prod1W'(pitch_i);
      xoff_q  <= grpw_pkg::XoffW'(ox_q) * grpw_pkg::XoffW'(bpp_i);
    end
    if (cmd_i.mul_bpp) begin
      prod2_q <= grpw_pkg::Prod2W'(prod1_q) * grpw_pkg::Prod2W'(bpp_i);
    end
    if (cmd_i.sum) begin
      addr_q <= base_i + grpw_pkg::AddrW'(prod2_q) + grpw_pkg::AddrW'(xoff_q);
    end
    if (cmd_i.emit) begin
      out_addr_q  <= addr_q;
      out_color_q <= bits_q[grpw_pkg::LeftBit] ? fg_q : bg_q;
      out_done_q  <= status_o.last_col;
      // step one pixel right, next bit to the left edge
      addr_q      <= addr_q + grpw_pkg::AddrW'(bpp_i);
      bits_q      <= bits_q << 1;
      col_q       <= col_q + grpw_pkg::ColW'(1);
    end
  end

  assign pixel_address_o = out_addr_q;
  assign pixel_color_o   = out_color_q;
  assign row_done_o      = out_done_q;

endmodule
